// ===== rtl/fvc_pkg.sv =====
// fvc_pkg: shared constants, types and tables for the flow-to-color block
// no dependencies
`timescale 1ns / 1ps

package fvc_pkg;

    localparam int FLOW_FRAC_BITS_DEF = 8;
    localparam int WHEEL_ENTRIES      = 55;
    localparam int CORDIC_STEPS       = 16;
    localparam int DIV_STEPS          = 33;
    localparam int ROOT_STEPS         = 17;
    localparam int APB_ADDR_W         = 3;
    localparam int CNT_W              = 6;

    // opcodes of an input beat
    localparam logic [1:0] OP_MEASURE = 2'd0;
    localparam logic [1:0] OP_RENDER  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // register index taken from paddr[2]
    localparam logic REG_MOTION_LIMIT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQM,
        ST_DIV,
        ST_ROOT,
        ST_RINIT,
        ST_ROT,
        ST_WHEEL,
        ST_MIXV,
        ST_MIXO,
        ST_OUT
    } fvc_state_t;

    // color wheel, {red, green, blue}
    localparam logic [23:0] WHEEL_LUT [WHEEL_ENTRIES] = '{
        24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400, 24'hFF5500,
        24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900, 24'hFFAA00, 24'hFFBB00,
        24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
        24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00, 24'h2BFF00,
        24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
        24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF, 24'h008CFF,
        24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF, 24'h0018FF,
        24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF, 24'h6200FF,
        24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF, 24'hC400FF, 24'hD700FF,
        24'hEB00FF,
        24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055, 24'hFF002B
    };

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

endpackage

// ===== rtl/fvc_if.sv =====
// fvc_in_if / fvc_out_if: valid-ready channels for flow beats and color beats
// no dependencies
`timescale 1ns / 1ps

interface fvc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic               flow_valid;

    modport source (output valid, opcode, flow_x, flow_y, flow_valid, input ready);
    modport sink   (input valid, opcode, flow_x, flow_y, flow_valid, output ready);
endinterface

interface fvc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/flow_vector_to_color.sv =====
// Render: squares, then inside the motion range the 33-step divider and the 17-step root, then the
// 16-step cordic (skipped for a vector on the x axis), wheel and mix; an invalid render goes straight
// to the color beat. A valid measure runs the squares of x and y and the root; other beats end at accept.
// One beat at a time: the next beat is taken only once this one is done; the iterative divider,
// root and cordic set the spacing, and a waiting color beat does not hold the next accept.
// Reset: rst_n async active low; clears control, motion_limit to 0, max to 1.0 (fvc_pkg, fvc_if).
`timescale 1ns / 1ps

module flow_vector_to_color #(
    parameter int FLOW_FRAC_BITS = fvc_pkg::FLOW_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    fvc_in_if.sink                           in_ch,
    fvc_out_if.source                        out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fvc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import fvc_pkg::*;

    localparam logic [15:0] MAX_RESET = 16'(1) << FLOW_FRAC_BITS;

    // control
    fvc_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg;
    logic [15:0]      max_radius_reg;
    logic [14:0]      motion_limit_reg;
    logic             in_ready;
    logic             in_fire;
    logic             out_load;

    // beat holding
    logic [1:0]         op_reg;
    logic signed [15:0] x_reg, y_reg;
    logic               fvalid_reg;

    // datapath registers
    logic [31:0]        s_reg, s_next;
    logic [31:0]        m2_reg, m2_next;
    logic               inside_reg, inside_next;
    logic [33:0]        div_rem_reg, div_rem_next;
    logic [32:0]        quo_reg, quo_next;
    logic [33:0]        sq_op_reg, sq_op_next;
    logic [19:0]        sq_rem_reg, sq_rem_next;
    logic [16:0]        sq_root_reg, sq_root_next;
    logic [16:0]        rn_reg, rn_next;
    logic signed [33:0] xs_reg, xs_next, ys_reg, ys_next, z_reg, z_next;
    logic [31:0]        t_reg, t_next;
    logic [5:0]         k0_reg, k0_next;
    logic [15:0]        f_reg, f_next;
    logic [23:0]        v_reg [3];
    logic [23:0]        v_next [3];
    logic [23:0]        rgb_reg, rgb_next;
    logic [7:0]         red_reg, green_reg, blue_reg;

    // combinational helpers
    logic [15:0]        abs_x, abs_y, range_m, mul_a;
    logic [31:0]        mul_prod;
    logic               div_ge;
    logic [33:0]        div_keep;
    logic [19:0]        sq_sh, sq_trial;
    logic               sq_ge;
    logic [3:0]         rot_i;
    logic signed [33:0] xs_sh, ys_sh, atan_s;
    logic signed [16:0] xn, yn;
    logic signed [33:0] z_sum;
    logic [37:0]        fk;
    logic [23:0]        c0, c1;
    logic [16:0]        f_inv;
    logic [24:0]        v_sum;
    logic [23:0]        v_gap;
    logic [40:0]        rn_prod;
    logic [41:0]        blend;
    logic [25:0]        scaled;

    assign in_fire  = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MOTION_LIMIT) ? {17'b0, motion_limit_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            motion_limit_reg <= 15'b0;
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MOTION_LIMIT)
            motion_limit_reg <= pwdata[14:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.opcode == OP_MEASURE && in_ch.flow_valid)
                        state_next = ST_SQX;
                    else if (in_ch.opcode == OP_RENDER)
                        state_next = in_ch.flow_valid ? ST_SQX : ST_OUT;
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = (op_reg == OP_MEASURE) ? ST_ROOT : ST_SQM;
            ST_SQM:  state_next = (s_reg <= mul_prod) ? ST_DIV : ST_RINIT;
            ST_DIV:  state_next = (cnt_reg == CNT_W'(DIV_STEPS - 1)) ? ST_ROOT : ST_DIV;
            ST_ROOT:
            begin
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                    state_next = (op_reg == OP_MEASURE) ? ST_IDLE : ST_RINIT;
            end
            ST_RINIT: state_next = (y_reg == 16'sd0) ? ST_WHEEL : ST_ROT;
            ST_ROT:   state_next = (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) ? ST_WHEEL : ST_ROT;
            ST_WHEEL: state_next = ST_MIXV;
            ST_MIXV:  state_next = ST_MIXO;
            ST_MIXO:  state_next = ST_OUT;
            ST_OUT:   state_next = out_load ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        cnt_next = '0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DIV:
            begin
                if (cnt_reg != CNT_W'(DIV_STEPS - 1))
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_ROOT:
            begin
                if (cnt_reg != CNT_W'(ROOT_STEPS - 1))
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_ROT:
            begin
                if (cnt_reg != CNT_W'(CORDIC_STEPS - 1))
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_OUT: out_load = !out_valid_reg || out_ch.ready;
            default: cnt_next = '0;
        endcase
    end

    // shared squarer operands and motion range
    always_comb
    begin
        abs_x = x_reg[15] ? 16'(-x_reg) : 16'(x_reg);
        abs_y = y_reg[15] ? 16'(-y_reg) : 16'(y_reg);
        if (motion_limit_reg != 15'b0)
            range_m = {1'b0, motion_limit_reg};
        else
            range_m = max_radius_reg;
        if (range_m == 16'b0)
            range_m = 16'd1;
        case (state_reg)
            ST_SQY:  mul_a = abs_y;
            ST_SQM:  mul_a = range_m;
            default: mul_a = abs_x;
        endcase
        mul_prod = {16'b0, mul_a} * {16'b0, mul_a};
    end

    // divider, square root and cordic steps
    always_comb
    begin
        div_ge   = div_rem_reg >= {2'b0, m2_reg};
        div_keep = div_ge ? (div_rem_reg - {2'b0, m2_reg}) : div_rem_reg;

        sq_sh    = {sq_rem_reg[17:0], sq_op_reg[33:32]};
        sq_trial = {1'b0, sq_root_reg, 2'b01};
        sq_ge    = sq_sh >= sq_trial;

        rot_i  = cnt_reg[3:0];
        xs_sh  = xs_reg >>> rot_i;
        ys_sh  = ys_reg >>> rot_i;
        atan_s = 34'(signed'({1'b0, CORDIC_ATAN[rot_i]}));

        xn = x_reg[15] ? -17'(x_reg) : 17'(x_reg);
        yn = x_reg[15] ? -17'(y_reg) : 17'(y_reg);
    end

    // datapath next values
    always_comb
    begin
        s_next       = s_reg;
        m2_next      = m2_reg;
        inside_next  = inside_reg;
        div_rem_next = div_rem_reg;
        quo_next     = quo_reg;
        sq_op_next   = sq_op_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        rn_next      = rn_reg;
        xs_next      = xs_reg;
        ys_next      = ys_reg;
        z_next       = z_reg;
        t_next       = t_reg;
        k0_next      = k0_reg;
        f_next       = f_reg;
        v_next       = v_reg;
        rgb_next     = rgb_reg;
        z_sum        = '0;
        fk           = '0;
        c0           = '0;
        c1           = '0;
        f_inv        = '0;
        v_sum        = '0;
        v_gap        = '0;
        rn_prod      = '0;
        blend        = '0;
        scaled       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                rgb_next = 24'b0;
            end
            ST_SQX:
            begin
                s_next = mul_prod;
            end
            ST_SQY:
            begin
                s_next       = s_reg + mul_prod;
                sq_op_next   = {2'b0, s_reg + mul_prod};
                sq_rem_next  = '0;
                sq_root_next = '0;
            end
            ST_SQM:
            begin
                m2_next      = mul_prod;
                inside_next  = s_reg <= mul_prod;
                div_rem_next = {2'b0, s_reg};
                quo_next     = '0;
            end
            ST_DIV:
            begin
                div_rem_next = {div_keep[32:0], 1'b0};
                quo_next     = {quo_reg[31:0], div_ge};
                sq_op_next   = {1'b0, quo_reg[31:0], div_ge};
                sq_rem_next  = '0;
                sq_root_next = '0;
            end
            ST_ROOT:
            begin
                sq_op_next   = {sq_op_reg[31:0], 2'b00};
                sq_rem_next  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
                sq_root_next = {sq_root_reg[15:0], sq_ge};
                rn_next      = {sq_root_reg[15:0], sq_ge};
            end
            ST_RINIT:
            begin
                xs_next = 34'(xn) <<< 14;
                ys_next = 34'(yn) <<< 14;
                z_next  = '0;
                t_next  = x_reg[15] ? 32'h80000000 : 32'h0;
            end
            ST_ROT:
            begin
                if (ys_reg > 34'sd0)
                begin
                    xs_next = xs_reg + ys_sh;
                    ys_next = ys_reg - xs_sh;
                    z_next  = z_reg + atan_s;
                end
                else
                begin
                    xs_next = xs_reg - ys_sh;
                    ys_next = ys_reg + xs_sh;
                    z_next  = z_reg - atan_s;
                end
                // add the half turn back, clamp small overshoots across +x
                z_sum = x_reg[15] ? (z_next + 34'sh080000000) : z_next;
                if (!x_reg[15] && y_reg > 16'sd0 && z_next < 34'sd0)
                    z_sum = '0;
                if (!x_reg[15] && y_reg < 16'sd0 && z_next >= 34'sd0)
                    z_sum = '1;
                t_next = z_sum[31:0];
            end
            ST_WHEEL:
            begin
                fk      = {6'b0, t_reg} * 38'd54;
                k0_next = fk[37:32];
                f_next  = fk[31:16];
            end
            ST_MIXV:
            begin
                c0    = WHEEL_LUT[k0_reg];
                c1    = WHEEL_LUT[k0_reg + 6'd1];
                f_inv = 17'h10000 - {1'b0, f_reg};
                for (int b = 0; b < 3; b++)
                begin
                    v_sum = 25'(f_inv) * 25'(c0[23 - 8*b -: 8])
                          + 25'(f_reg) * 25'(c1[23 - 8*b -: 8]);
                    v_next[b] = v_sum[23:0];
                end
            end
            ST_MIXO:
            begin
                for (int b = 0; b < 3; b++)
                begin
                    v_gap   = 24'hFF0000 - v_reg[b];
                    rn_prod = 41'(rn_reg) * 41'(v_gap);
                    blend   = (42'd255 << 32) - {1'b0, rn_prod};
                    scaled  = 26'(v_reg[b]) * 26'd3;
                    rgb_next[23 - 8*b -: 8] = inside_reg ? blend[39:32] : scaled[25:18];
                end
            end
            default:
            begin
                s_next = s_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            max_radius_reg <= MAX_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            // running maximum of the measured radius
            if (in_fire && in_ch.opcode == OP_CLEAR)
                max_radius_reg <= MAX_RESET;
            else if (state_reg == ST_ROOT && cnt_reg == CNT_W'(ROOT_STEPS - 1)
                     && op_reg == OP_MEASURE)
            begin
                if ({sq_root_reg[15:0], sq_ge} > {1'b0, max_radius_reg})
                    max_radius_reg <= sq_root_reg[15] ? 16'hFFFF : {sq_root_reg[14:0], sq_ge};
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= in_ch.opcode;
            x_reg      <= in_ch.flow_x;
            y_reg      <= in_ch.flow_y;
            fvalid_reg <= in_ch.flow_valid;
        end
        s_reg       <= s_next;
        m2_reg      <= m2_next;
        inside_reg  <= inside_next;
        div_rem_reg <= div_rem_next;
        quo_reg     <= quo_next;
        sq_op_reg   <= sq_op_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        rn_reg      <= rn_next;
        xs_reg      <= xs_next;
        ys_reg      <= ys_next;
        z_reg       <= z_next;
        t_reg       <= t_next;
        k0_reg      <= k0_next;
        f_reg       <= f_next;
        v_reg       <= v_next;
        rgb_reg     <= rgb_next;
        if (out_load)
        begin
            red_reg   <= fvalid_reg ? rgb_reg[23:16] : 8'b0;
            green_reg <= fvalid_reg ? rgb_reg[15:8]  : 8'b0;
            blue_reg  <= fvalid_reg ? rgb_reg[7:0]   : 8'b0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.red   = red_reg;
    assign out_ch.green = green_reg;
    assign out_ch.blue  = blue_reg;

endmodule

// ===== rtl/fvc_checker.sv =====
// fvc_port_props: port-level assertions for flow_vector_to_color, bound to the top level
// depends on fvc_pkg, flow_vector_to_color and the channel interfaces
`timescale 1ns / 1ps

module fvc_port_props (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);
    import fvc_pkg::*;

    // a stalled color beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("color beat dropped while stalled");

    // a stalled color beat keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("color beat changed while stalled");

    // a render beat keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_RENDER |=> !in_ready)
        else $error("second flow beat taken while busy");

    // a new color beat only comes from the busy phase
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("color beat appeared without work in progress");

endmodule

bind flow_vector_to_color fvc_port_props u_fvc_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .opcode    (in_ch.opcode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .red       (out_ch.red),
    .green     (out_ch.green),
    .blue      (out_ch.blue)
);
